>>> src/mrfd_pkg.sv
package mrfd_pkg;

    localparam logic [7:0] HEADER_BYTE  = 8'h3E;
    // frame byte positions: 0 header, 1..4 skipped, data from 5
    localparam logic [3:0] DATA_START   = 4'd5;
    localparam logic [3:0] STATUS_END   = 4'd12;  // checksum position, status reply
    localparam logic [3:0] POSITION_END = 4'd13;  // checksum position, position reply

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       expect_position;
    } mrfd_in_t;

    typedef struct packed {
        logic               reply_kind;
        logic               header_ok;
        logic               checksum_ok;
        logic signed [7:0]  temperature;
        logic signed [15:0] motor_current;
        logic signed [15:0] motor_speed;
        logic [15:0]        encoder_count;
        logic signed [63:0] raw_angle;
    } mrfd_out_t;

endpackage

>>> src/motor_reply_frame_decoder.sv
// Channel  | Ports                        | Moves
// ---------+------------------------------+-------------------------------------
// input    | s_valid, s_ready, s_data     | one received serial byte per request
// result   | m_valid, m_ready, m_data     | one decoded reply per complete frame
//
// One byte is taken per cycle while s_ready is high; it waits in the input
// register and is folded into the frame state when the processing stage moves,
// and a reply is loaded into the result register when its checksum byte moves.
// aresetn is synchronous, active low, and clears all control state.
// A stalled result register holds back the processing stage; an empty input
// register can still take one more byte while a finished reply waits, then
// s_ready drops until the reply is taken.
module motor_reply_frame_decoder (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  mrfd_pkg::mrfd_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output mrfd_pkg::mrfd_out_t m_data
);
    import mrfd_pkg::*;

    // input register
    logic       in_vld_reg, in_vld_next;
    mrfd_in_t   in_reg;

    // frame state
    logic        in_frame_reg, in_frame_next;
    logic [3:0]  byte_pos_reg, byte_pos_next;
    logic        kind_reg, kind_next;
    logic        hdr_ok_reg, hdr_ok_next;
    logic [7:0]  sum_reg, sum_next;
    logic [63:0] shift_reg, shift_next;

    // result register
    logic        out_vld_reg, out_vld_next;
    mrfd_out_t   out_reg, out_next;

    logic        advance;
    logic        emit;
    logic [3:0]  end_pos;
    logic [2:0]  lane;

    // the processing stage moves whenever it holds a byte and the result register has room
    assign advance = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;

    always_comb begin
        if (s_valid && s_ready) begin
            in_vld_next = 1'b1;
        end else if (advance) begin
            in_vld_next = 1'b0;
        end else begin
            in_vld_next = in_vld_reg;
        end
    end

    // data positions 5..12 map to lanes 0..7, so the low three bits suffice
    assign end_pos   = kind_reg ? POSITION_END : STATUS_END;
    assign lane      = byte_pos_reg[2:0] - DATA_START[2:0];
    assign emit      = advance && in_frame_reg && (byte_pos_reg == end_pos);

    // frame state update
    always_comb begin
        in_frame_next = in_frame_reg;
        byte_pos_next = byte_pos_reg;
        kind_next     = kind_reg;
        hdr_ok_next   = hdr_ok_reg;
        sum_next      = sum_reg;
        shift_next    = shift_reg;
        if (advance) begin
            if (!in_frame_reg) begin
                // idle: zero bytes are line filler
                if (in_reg.rx_byte != 8'd0) begin
                    in_frame_next = 1'b1;
                    byte_pos_next = 4'd1;
                    kind_next     = in_reg.expect_position;
                    hdr_ok_next   = (in_reg.rx_byte == HEADER_BYTE);
                    sum_next      = 8'd0;
                end
            end else if (byte_pos_reg < DATA_START) begin
                byte_pos_next = byte_pos_reg + 4'd1;
            end else if (byte_pos_reg < end_pos) begin
                sum_next                 = sum_reg + in_reg.rx_byte;
                shift_next[lane*8 +: 8]  = in_reg.rx_byte;
                byte_pos_next            = byte_pos_reg + 4'd1;
            end else begin
                // checksum byte closes the frame
                in_frame_next = 1'b0;
                byte_pos_next = 4'd0;
                kind_next     = 1'b0;
                hdr_ok_next   = 1'b0;
                sum_next      = 8'd0;
            end
        end
    end

    // result assembly, unused fields forced to zero
    always_comb begin
        out_next             = '0;
        out_next.reply_kind  = kind_reg;
        out_next.header_ok   = hdr_ok_reg;
        out_next.checksum_ok = (sum_reg == in_reg.rx_byte);
        if (kind_reg) begin
            out_next.raw_angle = shift_reg;
        end else begin
            out_next.temperature   = shift_reg[7:0];
            out_next.motor_current = shift_reg[23:8];
            out_next.motor_speed   = shift_reg[39:24];
            out_next.encoder_count = shift_reg[55:40];
        end
    end

    always_comb begin
        if (emit) begin
            out_vld_next = 1'b1;
        end else if (m_ready) begin
            out_vld_next = 1'b0;
        end else begin
            out_vld_next = out_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg   <= 1'b0;
            in_frame_reg <= 1'b0;
            byte_pos_reg <= 4'd0;
            kind_reg     <= 1'b0;
            hdr_ok_reg   <= 1'b0;
            sum_reg      <= 8'd0;
            out_vld_reg  <= 1'b0;
        end else begin
            in_vld_reg   <= in_vld_next;
            in_frame_reg <= in_frame_next;
            byte_pos_reg <= byte_pos_next;
            kind_reg     <= kind_next;
            hdr_ok_reg   <= hdr_ok_next;
            sum_reg      <= sum_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        shift_reg <= shift_next;
        if (emit) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

`ifndef SYNTHESIS
    a_idle_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_frame_reg |-> (byte_pos_reg == 4'd0) && (sum_reg == 8'd0))
        else $error("idle with stale frame state");

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        in_frame_reg |-> (byte_pos_reg != 4'd0) && (byte_pos_reg <= POSITION_END))
        else $error("byte position out of range");

    a_reply_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_vld_reg) |-> $past(emit))
        else $error("reply without checksum byte");

    a_header_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !in_frame_reg && (in_reg.rx_byte != 8'd0))
        |=> in_frame_reg && (hdr_ok_reg == ($past(in_reg.rx_byte) == HEADER_BYTE)))
        else $error("header flag not latched on frame start");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && !m_ready) |-> !emit)
        else $error("pending reply overwritten");
`endif

endmodule

>>> dv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mrfd_pkg::*;

    // data bytes per reply kind
    localparam int STATUS_BYTES   = 7;
    localparam int POSITION_BYTES = 8;
    localparam int MAX_REPORTS    = 10;

    // how the data bytes of a frame are filled
    typedef enum int {
        FILL_RANDOM,
        FILL_ZERO,
        FILL_ONES,
        FILL_EXTREME
    } fill_kind_t;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    mrfd_in_t  s_data;
    logic      m_valid;
    logic      m_ready;
    mrfd_out_t m_data;

    motor_reply_frame_decoder i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // ------------------------------------------------------------------
    // Clock and run limit
    // ------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Run limit, well beyond the length of the longest expected run.
    initial begin
        #2ms;
        $display("Timeout: decoder stopped making progress");
        $display("** motor_reply_frame_decoder: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // Frame predictor: a private copy of the parser state, advanced once
    // per accepted request. Finished replies queue up in order.
    // ------------------------------------------------------------------
    logic [3:0]  frm_pos;
    logic        frm_open;
    logic        frm_kind;
    logic        frm_hdr_ok;
    logic [7:0]  frm_sum;
    logic [63:0] frm_data;

    mrfd_out_t   expected_replies[$];

    int unsigned requests_sent;
    int unsigned frames_sent;
    int unsigned replies_checked;
    int unsigned reply_errors;

    // idle/stall odds in percent, changed per phase
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    // mirrors what s_valid is being driven to, so it is only lowered once
    bit          offering;

    task automatic clear_frame();
        frm_pos    = '0;
        frm_open   = 1'b0;
        frm_kind   = 1'b0;
        frm_hdr_ok = 1'b0;
        frm_sum    = '0;
        frm_data   = '0;
    endtask

    task automatic predict_byte(input mrfd_in_t req);
        mrfd_out_t rep;
        int        last_data;
        int        idx;
        last_data = DATA_START + (frm_kind ? POSITION_BYTES : STATUS_BYTES);
        if (!frm_open) begin
            // hunting: zero bytes vanish, anything else opens a frame
            if (req.rx_byte != 8'h00) begin
                frm_open   = 1'b1;
                frm_kind   = req.expect_position;
                frm_hdr_ok = (req.rx_byte == HEADER_BYTE);
                frm_sum    = '0;
                frm_data   = '0;
                frm_pos    = 4'd1;
            end
        end else if (frm_pos < DATA_START) begin
            frm_pos = frm_pos + 4'd1;
        end else if (int'(frm_pos) < last_data) begin
            idx = int'(frm_pos) - int'(DATA_START);
            frm_sum = frm_sum + req.rx_byte;
            frm_data[idx*8 +: 8] = req.rx_byte;
            frm_pos = frm_pos + 4'd1;
        end else begin
            // checksum byte closes the frame
            rep = '0;
            rep.reply_kind  = frm_kind;
            rep.header_ok   = frm_hdr_ok;
            rep.checksum_ok = (frm_sum == req.rx_byte);
            if (frm_kind) begin
                rep.raw_angle = frm_data;
            end else begin
                rep.temperature   = frm_data[7:0];
                rep.motor_current = frm_data[23:8];
                rep.motor_speed   = frm_data[39:24];
                rep.encoder_count = frm_data[55:40];
            end
            expected_replies.push_back(rep);
            clear_frame();
        end
    endtask

    // ------------------------------------------------------------------
    // Reply checker and result-side back-pressure
    // ------------------------------------------------------------------
    function automatic string reply_text(input mrfd_out_t r);
        return $sformatf("kind=%0d hdr=%0d cks=%0d temp=%0d cur=%0d spd=%0d enc=%0d ang=%h",
                         r.reply_kind, r.header_ok, r.checksum_ok, r.temperature,
                         r.motor_current, r.motor_speed, r.encoder_count, r.raw_angle);
    endfunction

    always @(posedge aclk) begin
        mrfd_out_t want;
        bit        bad;
        if (aresetn && m_valid && m_ready) begin
            if (expected_replies.size() == 0) begin
                reply_errors++;
                if (reply_errors <= MAX_REPORTS)
                    $display("%t: reply with none pending: %s", $realtime, reply_text(m_data));
            end else begin
                want = expected_replies.pop_front();
                bad  = (m_data.reply_kind    !== want.reply_kind)    ||
                       (m_data.header_ok     !== want.header_ok)     ||
                       (m_data.checksum_ok   !== want.checksum_ok)   ||
                       (m_data.temperature   !== want.temperature)   ||
                       (m_data.motor_current !== want.motor_current) ||
                       (m_data.motor_speed   !== want.motor_speed)   ||
                       (m_data.encoder_count !== want.encoder_count) ||
                       (m_data.raw_angle     !== want.raw_angle);
                replies_checked++;
                if (bad) begin
                    reply_errors++;
                    if (reply_errors <= MAX_REPORTS) begin
                        $display("%t: reply %0d mismatch", $realtime, replies_checked);
                        $display("    wanted %s", reply_text(want));
                        $display("    got    %s", reply_text(m_data));
                    end
                end
            end
        end
        // ready may drop whether or not a reply is waiting
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // Request driver. Called at a rising edge; returns at a rising edge.
    // Valid is only lowered when an idle gap is taken, so back-to-back
    // requests keep it high without a second assignment in one step.
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] rx, input logic want_position);
        mrfd_in_t req;
        req.rx_byte         = rx;
        req.expect_position = want_position;
        s_valid  <= 1'b1;
        s_data   <= req;
        offering = 1'b1;
        do @(posedge aclk); while (!s_ready);
        predict_byte(req);
        requests_sent++;
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_valid  <= 1'b0;
            offering = 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < send_idle_pct);
        end
    endtask

    // Stop offering requests and wait until every pending reply is back,
    // then let the pipeline settle.
    task automatic wait_for_replies();
        if (offering) begin
            s_valid  <= 1'b0;
            offering = 1'b0;
        end
        do @(posedge aclk); while (expected_replies.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    // One complete frame: header, four skipped bytes, data, checksum.
    // The reply-type bit is random on every byte after the header,
    // since the decoder should only look at it when a frame opens.
    task automatic send_frame(input logic kind, input logic hdr_good,
                              input logic cks_good, input fill_kind_t fill);
        logic [7:0] data_b;
        logic [7:0] sum;
        int         n;
        sum = '0;
        n   = kind ? POSITION_BYTES : STATUS_BYTES;
        send_byte(hdr_good ? HEADER_BYTE : 8'($urandom_range(1, 255)), kind);
        repeat (4)
            send_byte((fill == FILL_ZERO) ? 8'h00 : 8'($urandom_range(0, 255)), 1'($urandom));
        for (int i = 0; i < n; i++) begin
            case (fill)
                FILL_ZERO:    data_b = 8'h00;
                FILL_ONES:    data_b = 8'hFF;
                FILL_EXTREME: data_b = i[0] ? 8'h7F : 8'h80;
                default:      data_b = 8'($urandom_range(0, 255));
            endcase
            sum = sum + data_b;
            send_byte(data_b, 1'($urandom));
        end
        send_byte(cks_good ? sum : sum + 8'($urandom_range(1, 255)), 1'($urandom));
        frames_sent++;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Zeros while hunting are dropped; then a clean status frame with
    // sign-extreme data, and a position frame with a bad header and a
    // bad checksum so both flags are seen low.
    task automatic test_directed();
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b0);
        send_frame(1'b0, 1'b1, 1'b1, FILL_EXTREME);
        send_frame(1'b1, 1'b0, 1'b0, FILL_ONES);
        wait_for_replies();
    endtask

    // Mostly well-formed frames with random content, mixed with idle zero
    // noise, bad headers and bad checksums. Ends drained, so the sender
    // also pauses here until every reply has come.
    task automatic test_random_traffic(input int unsigned idle_pct,
                                       input int unsigned stall_pct);
        int unsigned start_requests;
        int unsigned start_frames;
        int unsigned roll;
        fill_kind_t  fill;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        start_requests = requests_sent;
        start_frames   = frames_sent;
        while (requests_sent - start_requests < 100 || frames_sent - start_frames < 9) begin
            // noise between frames can only be zeros, anything else opens one
            if ($urandom_range(0, 99) < 30)
                repeat ($urandom_range(1, 3)) send_byte(8'h00, 1'($urandom));
            roll = $urandom_range(0, 99);
            case ($urandom_range(0, 9))
                0:       fill = FILL_ZERO;
                1:       fill = FILL_ONES;
                2:       fill = FILL_EXTREME;
                default: fill = FILL_RANDOM;
            endcase
            if (roll < 70)
                send_frame(1'($urandom), 1'b1, 1'b1, fill);
            else if (roll < 85)
                send_frame(1'($urandom), 1'b1, 1'b0, fill);
            else
                send_frame(1'($urandom), 1'b0, 1'($urandom), fill);
        end
        wait_for_replies();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn         <= 1'b0;
        s_valid         <= 1'b0;
        s_data          <= '0;
        m_ready         <= 1'b0;
        offering        = 1'b0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        requests_sent   = 0;
        frames_sent     = 0;
        replies_checked = 0;
        reply_errors    = 0;
        clear_frame();

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random_traffic(0, 0);     // full rate both ways
        test_random_traffic(67, 0);    // sparse requests
        test_random_traffic(0, 67);    // heavy result back-pressure
        test_random_traffic(35, 35);   // both sides gapping

        repeat (10) @(posedge aclk);
        if (expected_replies.size() != 0) begin
            reply_errors += expected_replies.size();
            $display("%0d replies never arrived", expected_replies.size());
        end

        $display("Sent %0d byte requests in %0d frames over four idle/stall mixes;",
                 requests_sent, frames_sent);
        $display("checked %0d decoded replies, %0d errors.", replies_checked, reply_errors);
        if (reply_errors == 0)
            $display("** motor_reply_frame_decoder: PASSED **");
        else
            $display("** motor_reply_frame_decoder: FAILED **");
        $finish;
    end

endmodule
